[rtl/tcd_pkg.sv]
// shared widths, types and constants of the triangle coverage and depth unit
package tcd_pkg;

  localparam int COORD_BITS       = 23;
  localparam int WEIGHT_FRAC_BITS = 10;

  // derived widths
  localparam int DIFF_W = COORD_BITS + 1;        // signed coordinate difference
  localparam int PROD_W = 2 * DIFF_W;            // signed cross product term
  localparam int EDGE_W = PROD_W + 1;            // signed edge function
  localparam int MAG_W  = PROD_W;                // edge function magnitude
  localparam int AREA_W = MAG_W + 2;             // sum of three magnitudes
  localparam int REM_W  = AREA_W + 1;            // divider partial remainder
  localparam int WGT_W  = WEIGHT_FRAC_BITS + 1;  // weight, 0 .. 2^W
  localparam int WZ_W   = WGT_W + COORD_BITS;    // weight times depth
  localparam int ACC_W  = WZ_W + 2;              // sum of three weighted depths

  localparam logic [WGT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  typedef logic [COORD_BITS-1:0] coord_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic         covered;
    coord_t [2:0] z;
  } side_t;

endpackage

[rtl/tcd_if.sv]
// item channels of the triangle coverage and depth unit

interface tcd_in_if;
  logic                valid;
  logic                ready;
  tcd_pkg::coord_t     sample_x;
  tcd_pkg::coord_t     sample_y;
  tcd_pkg::coord_t     v0_x;
  tcd_pkg::coord_t     v0_y;
  tcd_pkg::coord_t     v0_z;
  tcd_pkg::coord_t     v1_x;
  tcd_pkg::coord_t     v1_y;
  tcd_pkg::coord_t     v1_z;
  tcd_pkg::coord_t     v2_x;
  tcd_pkg::coord_t     v2_y;
  tcd_pkg::coord_t     v2_z;

  modport source (
    output valid, sample_x, sample_y, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
           v2_x, v2_y, v2_z,
    input  ready
  );
  modport sink (
    input  valid, sample_x, sample_y, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
           v2_x, v2_y, v2_z,
    output ready
  );
endinterface

interface tcd_out_if;
  logic            valid;
  logic            ready;
  logic            covered;
  tcd_pkg::coord_t depth;

  modport source (output valid, covered, depth, input ready);
  modport sink (input valid, covered, depth, output ready);
endinterface

[rtl/triangle_coverage_depth_unit.sv]
// top level of the triangle coverage and depth unit
//
// in_i carries one sample point and one triangle (three vertices with depth)
// per item; out_o returns one item per input: covered and interpolated depth.
// both channels use valid/ready, an item moves when both are high.
//
// throughput: one item per cycle while out_o is not stalled.
// pipeline stages from acceptance to out_o.valid, in order:
//   coordinate differences, cross products, edge functions, magnitudes
//   and sign test, area, divider (one quotient bit per stage, both
//   weights in parallel), third weight, weighted depths, sum and output
//   register.
// the whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken, so in_i.ready follows out_o.ready and
// a stall freezes every stage in place, nothing lost or repeated.
// reset (rst_ni low, asynchronous) clears all valid bits; the block takes
// items from the first cycle after reset.
// a degenerate triangle (zero area) and an uncovered sample give covered 0
// and depth 0.
module triangle_coverage_depth_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcd_in_if.sink   in_i,
  tcd_out_if.source out_o
);

  localparam int C = tcd_pkg::COORD_BITS;
  localparam int W = tcd_pkg::WEIGHT_FRAC_BITS;

  // global pipeline enable
  logic adv;
  logic out_vld_q;
  logic out_cov_q;
  tcd_pkg::coord_t out_depth_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // vertex views of the input item
  tcd_pkg::coord_t vx [3];
  tcd_pkg::coord_t vy [3];
  tcd_pkg::coord_t vz [3];

  always_comb begin
    vx[0] = in_i.v0_x; vy[0] = in_i.v0_y; vz[0] = in_i.v0_z;
    vx[1] = in_i.v1_x; vy[1] = in_i.v1_y; vz[1] = in_i.v1_z;
    vx[2] = in_i.v2_x; vy[2] = in_i.v2_y; vz[2] = in_i.v2_z;
  end

  // ---------------------------------------------------------------------
  // stage 1: differences, edge k runs from vertex k to vertex k+1
  logic                               s1_vld_q;
  logic signed [tcd_pkg::DIFF_W-1:0]  dx_d [3], dy_d [3], ex_d [3], ey_d [3];
  logic signed [tcd_pkg::DIFF_W-1:0]  dx_q [3], dy_q [3], ex_q [3], ey_q [3];
  tcd_pkg::coord_t                    s1_z_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx_d[k] = $signed({1'b0, in_i.sample_x}) - $signed({1'b0, vx[k]});
      dy_d[k] = $signed({1'b0, in_i.sample_y}) - $signed({1'b0, vy[k]});
      ex_d[k] = $signed({1'b0, vx[(k + 1) % 3]}) - $signed({1'b0, vx[k]});
      ey_d[k] = $signed({1'b0, vy[(k + 1) % 3]}) - $signed({1'b0, vy[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dx_q[k]   <= dx_d[k];
        dy_q[k]   <= dy_d[k];
        ex_q[k]   <= ex_d[k];
        ey_q[k]   <= ey_d[k];
        s1_z_q[k] <= vz[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: cross product terms, one multiplier each
  logic                               s2_vld_q;
  logic signed [tcd_pkg::PROD_W-1:0]  pa_q [3], pb_q [3];
  tcd_pkg::coord_t                    s2_z_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k]   <= dx_q[k] * ey_q[k];
        pb_q[k]   <= dy_q[k] * ex_q[k];
        s2_z_q[k] <= s1_z_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: edge functions
  logic                               s3_vld_q;
  logic signed [tcd_pkg::EDGE_W-1:0]  e_q [3];
  tcd_pkg::coord_t                    s3_z_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e_q[k]    <= tcd_pkg::EDGE_W'(pa_q[k]) - tcd_pkg::EDGE_W'(pb_q[k]);
        s3_z_q[k] <= s2_z_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: magnitudes and common sign test, zero counts as either sign
  logic                              s4_vld_q;
  logic [tcd_pkg::MAG_W-1:0]         m_d [3], m_q [3];
  logic [tcd_pkg::EDGE_W-1:0]        e_neg [3];
  logic                              any_neg, any_pos;
  logic                              s4_same_q;
  tcd_pkg::coord_t                   s4_z_q [3];

  always_comb begin
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e_neg[k] = '0 - e_q[k];
      m_d[k]   = e_q[k][tcd_pkg::EDGE_W-1] ? e_neg[k][tcd_pkg::MAG_W-1:0]
                                           : e_q[k][tcd_pkg::MAG_W-1:0];
      any_neg  = any_neg | e_q[k][tcd_pkg::EDGE_W-1];
      any_pos  = any_pos | (!e_q[k][tcd_pkg::EDGE_W-1] && (e_q[k] != '0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_same_q <= !(any_neg && any_pos);
      for (int k = 0; k < 3; k++) begin
        m_q[k]    <= m_d[k];
        s4_z_q[k] <= s3_z_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: sum of edge magnitudes (twice the triangle area when covered), coverage decision
  logic                              s5_vld_q;
  logic [tcd_pkg::AREA_W-1:0]        area_d, area_q;
  logic [tcd_pkg::MAG_W-1:0]         s5_m1_q, s5_m2_q;
  tcd_pkg::side_t                    s5_side_q;

  assign area_d = tcd_pkg::AREA_W'(m_q[0]) + tcd_pkg::AREA_W'(m_q[1])
                + tcd_pkg::AREA_W'(m_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_q            <= area_d;
      s5_m1_q           <= m_q[1];
      s5_m2_q           <= m_q[2];
      s5_side_q.covered <= s4_same_q && (area_d != '0);
      for (int k = 0; k < 3; k++) begin
        s5_side_q.z[k] <= s4_z_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stages 6..16: weights w0 = m1 / area, w1 = m2 / area, W fraction bits
  logic                          dv_vld;
  logic [tcd_pkg::WGT_W-1:0]     q0, q1;
  tcd_pkg::side_t                dv_side;

  tcd_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s5_vld_q),
    .num0_i  (s5_m1_q),
    .num1_i  (s5_m2_q),
    .den_i   (area_q),
    .side_i  (s5_side_q),
    .valid_o (dv_vld),
    .q0_o    (q0),
    .q1_o    (q1),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------
  // stage 17: third weight makes the sum exactly one
  logic                          s6_vld_q;
  logic [tcd_pkg::WGT_W-1:0]     w_q [3];
  tcd_pkg::side_t                s6_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q[0]    <= q0;
      w_q[1]    <= q1;
      w_q[2]    <= tcd_pkg::WEIGHT_ONE - q0 - q1;
      s6_side_q <= dv_side;
    end
  end

  // ---------------------------------------------------------------------
  // stage 18: weighted depths
  logic                          s7_vld_q;
  logic [tcd_pkg::WZ_W-1:0]      wz_q [3];
  logic                          s7_cov_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        wz_q[k] <= w_q[k] * s6_side_q.z[k];
      end
      s7_cov_q <= s6_side_q.covered;
    end
  end

  // ---------------------------------------------------------------------
  // stage 19: sum, drop fraction bits, output register
  logic [tcd_pkg::ACC_W-1:0]     acc;

  assign acc = tcd_pkg::ACC_W'(wz_q[0]) + tcd_pkg::ACC_W'(wz_q[1])
             + tcd_pkg::ACC_W'(wz_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cov_q   <= s7_cov_q;
      out_depth_q <= s7_cov_q ? acc[W +: C] : '0;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= dv_vld;
      s7_vld_q  <= s6_vld_q;
      out_vld_q <= s7_vld_q;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.covered = out_cov_q;
  assign out_o.depth   = out_depth_q;

  // ---------------------------------------------------------------------
  // checks

  // an uncovered result never carries a depth
  a_uncov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.covered |-> out_o.depth == '0)
    else $error("uncovered item with nonzero depth");

  // an item in stage 4 reaches stage 5 when the pipeline moves
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s4_vld_q |=> s5_vld_q)
    else $error("item dropped between stage 4 and stage 5");

  // a stalled pipeline does not shift its valid bits s5_vld_q and s7_vld_q
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s5_vld_q) && $stable(s7_vld_q))
    else $error("pipeline moved while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_o.valid)
    else $error("result present straight after reset");

endmodule

[rtl/tcd_div_pipe.sv]
// pipelined restoring divider giving two fractional weights, one quotient bit per stage
module tcd_div_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [tcd_pkg::MAG_W-1:0]           num0_i,
  input  logic [tcd_pkg::MAG_W-1:0]           num1_i,
  input  logic [tcd_pkg::AREA_W-1:0]          den_i,
  input  tcd_pkg::side_t                      side_i,
  output logic                                valid_o,
  output logic [tcd_pkg::WGT_W-1:0]           q0_o,
  output logic [tcd_pkg::WGT_W-1:0]           q1_o,
  output tcd_pkg::side_t                      side_o
);

  localparam int NSTG  = tcd_pkg::WGT_W;
  localparam int REM_W = tcd_pkg::REM_W;
  localparam int QW    = tcd_pkg::WGT_W;

  logic                          vld_q  [NSTG];
  logic [REM_W-1:0]              r0_q   [NSTG];
  logic [REM_W-1:0]              r1_q   [NSTG];
  logic [QW-1:0]                 q0_q   [NSTG];
  logic [QW-1:0]                 q1_q   [NSTG];
  logic [tcd_pkg::AREA_W-1:0]    den_q  [NSTG];
  tcd_pkg::side_t                side_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_step
    logic [REM_W-1:0]           t0, t1;
    logic [REM_W-1:0]           dn;
    logic [tcd_pkg::AREA_W-1:0] den_in;
    logic [QW-1:0]              qp0, qp1;
    logic                       ge0, ge1;
    tcd_pkg::side_t             side_in;
    logic                       vld_in;

    if (k == 0) begin : g_first
      // first step compares the unshifted numerator
      assign t0      = REM_W'(num0_i);
      assign t1      = REM_W'(num1_i);
      assign den_in  = den_i;
      assign qp0     = '0;
      assign qp1     = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign t0      = {r0_q[k-1][REM_W-2:0], 1'b0};
      assign t1      = {r1_q[k-1][REM_W-2:0], 1'b0};
      assign den_in  = den_q[k-1];
      assign qp0     = q0_q[k-1];
      assign qp1     = q1_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign dn  = REM_W'(den_in);
    assign ge0 = (t0 >= dn);
    assign ge1 = (t1 >= dn);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r0_q[k]   <= ge0 ? (t0 - dn) : t0;
        r1_q[k]   <= ge1 ? (t1 - dn) : t1;
        q0_q[k]   <= {qp0[QW-2:0], ge0};
        q1_q[k]   <= {qp1[QW-2:0], ge1};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign q0_o    = q0_q[NSTG-1];
  assign q1_o    = q1_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

[tb/testbench.sv]
// self-checking testbench for the triangle coverage and depth unit
`timescale 1ns / 1ps

module testbench;
  import tcd_pkg::*;

  // one sample point and one triangle, as the input channel carries them
  typedef struct {
    coord_t sample_x, sample_y;
    coord_t v0_x, v0_y, v0_z;
    coord_t v1_x, v1_y, v1_z;
    coord_t v2_x, v2_y, v2_z;
  } triangle_item_t;

  // what the output channel should return for one item
  typedef struct {
    logic   covered;
    coord_t depth;
  } coverage_t;

  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam longint      WEIGHT_SUM = longint'(1) << WEIGHT_FRAC_BITS;
  localparam int          ITEMS_PER_PHASE = 475;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tcd_in_if  in_if ();
  tcd_out_if out_if ();

  triangle_coverage_depth_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  triangle_item_t pending_triangles[$];   // items waiting for the driver
  coverage_t      coverage_expected[$];   // predictions waiting for the output
  triangle_item_t next_triangle;
  triangle_item_t taken_triangle;
  coverage_t      seen_result;
  coverage_t      want_result;

  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  int  items_queued       = 0;
  int  items_taken        = 0;
  int  mismatches         = 0;
  bit  in_taken           = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // signed cross product (s - a) x (b - a)
  function automatic longint edge_cross(longint sx, longint sy, longint ax, longint ay,
                                        longint bx, longint by);
    return (sx - ax) * (by - ay) - (sy - ay) * (bx - ax);
  endfunction

  function automatic longint abs_edge(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // floor(num * 2^W / den) for num <= den, by restoring division one bit at a time
  function automatic longint weight_quotient(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = num;
    if (r >= den) begin
      q = 1;
      r -= den;
    end
    for (int k = 0; k < WEIGHT_FRAC_BITS; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic coverage_t predict_coverage_depth(triangle_item_t t);
    coverage_t res;
    longint e0, e1, e2, area, w0, w1, w2, acc;
    bit     same_sign;
    e0 = edge_cross(t.sample_x, t.sample_y, t.v0_x, t.v0_y, t.v1_x, t.v1_y);
    e1 = edge_cross(t.sample_x, t.sample_y, t.v1_x, t.v1_y, t.v2_x, t.v2_y);
    e2 = edge_cross(t.sample_x, t.sample_y, t.v2_x, t.v2_y, t.v0_x, t.v0_y);
    // zero counts as either sign, so a sample on an edge is inside
    same_sign = (e0 <= 0 && e1 <= 0 && e2 <= 0) || (e0 >= 0 && e1 >= 0 && e2 >= 0);
    area = abs_edge(e0) + abs_edge(e1) + abs_edge(e2);
    res.covered = 1'b0;
    res.depth   = '0;
    if (same_sign && area != 0) begin
      w0  = weight_quotient(abs_edge(e1), area);
      w1  = weight_quotient(abs_edge(e2), area);
      w2  = WEIGHT_SUM - w0 - w1;
      acc = w0 * longint'(t.v0_z) + w1 * longint'(t.v1_z) + w2 * longint'(t.v2_z);
      res.covered = 1'b1;
      res.depth   = coord_t'(acc >>> WEIGHT_FRAC_BITS);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic triangle_item_t make_triangle(
      longint sx, longint sy, longint x0, longint y0, longint z0, longint x1, longint y1,
      longint z1, longint x2, longint y2, longint z2);
    triangle_item_t t;
    t.sample_x = coord_t'(sx);
    t.sample_y = coord_t'(sy);
    t.v0_x = coord_t'(x0);
    t.v0_y = coord_t'(y0);
    t.v0_z = coord_t'(z0);
    t.v1_x = coord_t'(x1);
    t.v1_y = coord_t'(y1);
    t.v1_z = coord_t'(z1);
    t.v2_x = coord_t'(x2);
    t.v2_y = coord_t'(y2);
    t.v2_z = coord_t'(z2);
    return t;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // mostly samples inside or on the triangle, the rest near a corner or anywhere
  function automatic triangle_item_t random_triangle();
    longint      vx[3], vy[3], vz[3], wt[3];
    longint      base_x, base_y, span, sx, sy, wsum;
    int unsigned shape, pick, corner;
    shape = $urandom_range(0, 9);
    if (shape < 3) begin
      span = COORD_MAX;
    end else if (shape < 7) begin
      span = longint'(1) << $urandom_range(2, 10);
    end else begin
      span = longint'(1) << $urandom_range(11, 20);
    end
    base_x = $urandom_range(0, COORD_MAX - span);
    base_y = $urandom_range(0, COORD_MAX - span);
    for (int i = 0; i < 3; i++) begin
      vx[i] = base_x + $urandom_range(0, span);
      vy[i] = base_y + $urandom_range(0, span);
      vz[i] = $urandom_range(0, COORD_MAX);
      wt[i] = $urandom_range(0, 255);
    end
    pick   = $urandom_range(0, 19);
    corner = $urandom_range(0, 2);
    if (pick < 10) begin
      // interior point, weights as drawn
    end else if (pick < 13) begin
      wt[corner] = 0;                       // on the opposite edge
    end else if (pick < 15) begin
      wt = '{0, 0, 0};
      wt[corner] = 1;                       // exactly on a vertex
    end
    wsum = wt[0] + wt[1] + wt[2];
    if (wsum == 0) begin
      wt[corner] = 1;
      wsum = 1;
    end
    sx = (wt[0] * vx[0] + wt[1] * vx[1] + wt[2] * vx[2]) / wsum;
    sy = (wt[0] * vy[0] + wt[1] * vy[1] + wt[2] * vy[2]) / wsum;
    if (pick >= 15 && pick < 18) begin
      // just off a vertex, often outside
      sx = clamp_coord(vx[corner] + longint'($urandom_range(0, 64)) - 32);
      sy = clamp_coord(vy[corner] + longint'($urandom_range(0, 64)) - 32);
    end else if (pick >= 18) begin
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
    end
    return make_triangle(sx, sy, vx[0], vy[0], vz[0], vx[1], vy[1], vz[1],
                         vx[2], vy[2], vz[2]);
  endfunction

  task automatic queue_triangle(triangle_item_t t);
    pending_triangles.insert(pending_triangles.size(), t);
    items_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      // present a new item only once the current one has gone
      if (!in_if.valid || in_taken) begin
        if (pending_triangles.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_triangle   = pending_triangles.pop_front();
          in_if.valid    <= 1'b1;
          in_if.sample_x <= next_triangle.sample_x;
          in_if.sample_y <= next_triangle.sample_y;
          in_if.v0_x     <= next_triangle.v0_x;
          in_if.v0_y     <= next_triangle.v0_y;
          in_if.v0_z     <= next_triangle.v0_z;
          in_if.v1_x     <= next_triangle.v1_x;
          in_if.v1_y     <= next_triangle.v1_y;
          in_if.v1_z     <= next_triangle.v1_z;
          in_if.v2_x     <= next_triangle.v2_x;
          in_if.v2_y     <= next_triangle.v2_y;
          in_if.v2_z     <= next_triangle.v2_z;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_if.valid && in_if.ready;

    // accepted input item: predict its result
    if (rst_ni && in_if.valid && in_if.ready) begin
      taken_triangle.sample_x = in_if.sample_x;
      taken_triangle.sample_y = in_if.sample_y;
      taken_triangle.v0_x     = in_if.v0_x;
      taken_triangle.v0_y     = in_if.v0_y;
      taken_triangle.v0_z     = in_if.v0_z;
      taken_triangle.v1_x     = in_if.v1_x;
      taken_triangle.v1_y     = in_if.v1_y;
      taken_triangle.v1_z     = in_if.v1_z;
      taken_triangle.v2_x     = in_if.v2_x;
      taken_triangle.v2_y     = in_if.v2_y;
      taken_triangle.v2_z     = in_if.v2_z;
      coverage_expected.insert(coverage_expected.size(),
                               predict_coverage_depth(taken_triangle));
      items_taken++;
    end

    // accepted result item: compare with the oldest prediction
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_result.covered = out_if.covered;
      seen_result.depth   = out_if.depth;
      if (coverage_expected.size() == 0) begin
        $error("unexpected result: covered %0d depth %0d", seen_result.covered,
               seen_result.depth);
        mismatches++;
      end else begin
        want_result = coverage_expected.pop_front();
        if (seen_result.covered !== want_result.covered) begin
          $error("covered: expected %0d, got %0d", want_result.covered, seen_result.covered);
          mismatches++;
        end
        if (seen_result.depth !== want_result.depth) begin
          $error("depth: expected %0d, got %0d", want_result.depth, seen_result.depth);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    longint m;
    longint h;
    m = COORD_MAX;
    h = longint'(1) << 22;

    // known values on every input before the first edge
    in_if.valid    = 1'b0;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    in_if.v0_x     = '0;
    in_if.v0_y     = '0;
    in_if.v0_z     = '0;
    in_if.v1_x     = '0;
    in_if.v1_y     = '0;
    in_if.v1_z     = '0;
    in_if.v2_x     = '0;
    in_if.v2_y     = '0;
    in_if.v2_z     = '0;
    out_if.ready   = 1'b0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed items, sent without idling
    // degenerate: every coordinate zero, then every coordinate at its maximum
    queue_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_triangle(make_triangle(m, m, m, m, m, m, m, m, m, m, m));
    // full-size triangle, one winding: on a vertex, inside, outside, on another vertex
    queue_triangle(make_triangle(0, 0, 0, 0, 0, m, 0, m, 0, m, m / 2));
    queue_triangle(make_triangle(m / 4, m / 4, 0, 0, 0, m, 0, m, 0, m, m / 2));
    queue_triangle(make_triangle(m, m, 0, 0, 0, m, 0, m, 0, m, m / 2));
    queue_triangle(make_triangle(m, 0, 0, 0, 0, m, 0, m, 0, m, m / 2));
    // the other winding
    queue_triangle(make_triangle(m / 4, m / 4, 0, 0, m, 0, m, 0, m, 0, 0));
    queue_triangle(make_triangle(m / 3, m / 2, 0, 0, m, 0, m, 0, m, 0, 0));
    // sample exactly on the long edge
    queue_triangle(make_triangle(h / 2, h / 2, 0, 0, 100, h, 0, 200, 0, h, 300));
    // collinear triangle, sample on its line and off it
    queue_triangle(make_triangle(50, 50, 0, 0, 7, 100, 100, 8, 200, 200, 9));
    queue_triangle(make_triangle(50, 60, 0, 0, 7, 100, 100, 8, 200, 200, 9));
    // top corner of the coordinate range, first with all depths at maximum
    queue_triangle(make_triangle(m - 1, m - 1, m, m, m, m, 0, m, 0, m, m));
    queue_triangle(make_triangle(m, m, m, m, m, m, 0, 0, 0, m, 0));
    // alternating bit patterns
    queue_triangle(make_triangle(24'h555555 & m, 24'h2AAAAA & m, 0, 0, 24'h2AAAAA & m,
                                 m, 24'h155555, 24'h555555 & m, 24'h2AAAAA & m, m, 1));
    queue_triangle(make_triangle(24'h2AAAAA & m, 24'h555555 & m, m, 0, 24'h555555 & m,
                                 0, m, 24'h2AAAAA & m, m, m, m - 1));
    // tiny triangle of one unit
    queue_triangle(make_triangle(1, 1, 1, 1, 3, 2, 1, 5, 1, 2, 9));

    // four idling phases, each filled once the previous one has drained
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 48;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 48;
        end
        default: begin
          sender_idle_pct    = 8;
          receiver_stall_pct = 8;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) queue_triangle(random_triangle());
      while (pending_triangles.size() != 0) @(posedge clk_i);
    end

    // drain: every item taken, every result back, then a further wait
    wait (items_taken == items_queued);
    receiver_stall_pct = 0;
    while (coverage_expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
rtl/tcd_pkg.sv
rtl/tcd_if.sv
rtl/tcd_div_pipe.sv
rtl/triangle_coverage_depth_unit.sv
tb/testbench.sv
